// ===== sv/range_max_subarray_sum_tree_defines.svh =====
// Assertion macros used by the block's top module.
`ifndef RANGE_MAX_SUBARRAY_SUM_TREE_DEFINES_SVH
`define RANGE_MAX_SUBARRAY_SUM_TREE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RMSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define RMSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rmss_pkg.sv =====
package rmss_pkg;

  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned ACC_W      = 34;

  // Minus infinity of the max-plus algebra.
  localparam logic signed [SUM_W-1:0] NEG_INF = -32'sh3f3f3f3f;

  typedef logic signed [SUM_W-1:0] ent_t;
  typedef ent_t [8:0] mat_t;

  // Matrix that one leaf value stands for.
  function automatic mat_t leaf_mat(input logic signed [VAL_W-1:0] v);
    mat_t m;
    ent_t e;
    e = ent_t'(v);
    m[0] = e;       m[1] = NEG_INF; m[2] = e;
    m[3] = e;       m[4] = '0;      m[5] = e;
    m[6] = NEG_INF; m[7] = NEG_INF; m[8] = '0;
    return m;
  endfunction

endpackage

// ===== sv/rmss_ram.sv =====
module rmss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/rmss_mul.sv =====
// Sequential max-plus product r = a * b: one entry of r per step, the three
// sums of that entry compared in parallel.
module rmss_mul
  import rmss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  mat_t a,
  input  mat_t b,
  output logic done,
  output mat_t r
);

  logic [3:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt;
  logic [1:0] i, j;
  logic signed [ACC_W-1:0] s0, s1, s2, best;
  mat_t r_r;

  // Row and column of the entry in progress, stepped alongside the count.
  assign i = i_r;
  assign j = j_r;

  // Candidate sums for entry (i, j), floored at minus infinity.
  always_comb begin
    logic signed [ACC_W-1:0] m;
    s0 = ACC_W'(a[i*3+0]) + ACC_W'(b[0*3+j]);
    s1 = ACC_W'(a[i*3+1]) + ACC_W'(b[1*3+j]);
    s2 = ACC_W'(a[i*3+2]) + ACC_W'(b[2*3+j]);
    m = ACC_W'(NEG_INF);
    if (s0 > m) m = s0;
    if (s1 > m) m = s1;
    if (s2 > m) m = s2;
    best = m;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      i_nxt    = '0;
      j_nxt    = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 4'd1;
      if (j_r == 2'd2) begin
        j_nxt = '0;
        i_nxt = i_r + 2'd1;
      end else begin
        j_nxt = j_r + 2'd1;
      end
      if (cnt_r == 4'd8) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      i_r    <= '0;
      j_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
    end
    if (busy_r && !start) r_r[cnt_r] <= best[SUM_W-1:0];
  end

  assign done = busy_r && (cnt_r == 4'd8) && !start;
  always_comb begin
    r = r_r;
    r[8] = best[SUM_W-1:0];
  end

endmodule

// ===== sv/range_max_subarray_sum_tree.sv =====
// One item at a time; a bad query goes straight to the output state.
// The rate is set by the shared nine-step matrix unit and the node memory,
// which has one write port and one registered read port.
// After reset a clearing pass writes the zero tree, level by level, during
// which no item is accepted. active_length resets to 1024.
module range_max_subarray_sum_tree
  import rmss_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, low bit up: mode[0], first_index[11:1], last_index[22:12],
  // new_value[38:23], zero fill[39].
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, low bit up: best_sum[31:0], status[32], zero fill[39:33].
  output logic [39:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);

  `include "range_max_subarray_sum_tree_defines.svh"

  localparam int unsigned LVL   = $clog2(LEAVES);
  localparam int unsigned NODES = 2 * (1 << LVL);
  localparam int unsigned AW    = $clog2(NODES);
  localparam int unsigned PW    = LVL + 1;
  localparam int unsigned MW    = $bits(mat_t);
  localparam int unsigned SP    = 2 * LVL + 4;
  localparam logic [PW-1:0] LEAF_BASE = PW'(1 << LVL);

  // Sequencer states.
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_URD   = 4'd2;
  localparam logic [3:0] S_UWT   = 4'd3;
  localparam logic [3:0] S_UMUL  = 4'd4;
  localparam logic [3:0] S_QPOP  = 4'd5;
  localparam logic [3:0] S_QRD   = 4'd6;
  localparam logic [3:0] S_QWT   = 4'd7;
  localparam logic [3:0] S_QMUL  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_CRD   = 4'd10;
  localparam logic [3:0] S_CWT   = 4'd11;
  localparam logic [3:0] S_CMUL  = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  alen_r;
  logic [AW-1:0]     node_r, node_nxt;
  logic [1:0]        ph_r, ph_nxt;
  mat_t              a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic              acc_v_r, acc_v_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              st_r, st_nxt;
  logic [IDX_W-1:0]  qa_r, qa_nxt, qb_r, qb_nxt;

  // Explicit stack of (node, lo, hi) for the query walk.
  logic [AW-1:0]     stk_n_r  [SP];
  logic [PW-1:0]     stk_lo_r [SP];
  logic [PW-1:0]     stk_hi_r [SP];
  logic [$clog2(SP+1)-1:0] sp_r, sp_nxt;
  logic              push_a, push_b;
  logic [AW-1:0]     pa_n, pb_n;
  logic [PW-1:0]     pa_lo, pa_hi, pb_lo, pb_hi;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  mat_t              wdata, rdata;
  logic              mstart, mdone;
  mat_t              mres;

  logic [IDX_W:0]    limit;
  logic              in_fire, out_fire;
  logic              i_mode;
  logic [IDX_W-1:0]  i_first, i_last;
  logic signed [VAL_W-1:0] i_val;

  assign i_mode  = in_tdata[0];
  assign i_first = in_tdata[11:1];
  assign i_last  = in_tdata[22:12];
  assign i_val   = in_tdata[38:23];
  assign limit   = (alen_r < IDX_W'(LEAVES)) ? {1'b0, alen_r} : (IDX_W+1)'(LEAVES);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_fire   = out_tvalid && out_tready;
  assign out_tdata  = {7'd0, st_r, sum_r};

  rmss_ram #(.WIDTH(MW), .DEPTH(NODES)) u_ram (
    .clk(clk), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
    .rd_addr(raddr), .rd_data(rdata)
  );

  rmss_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(a_r), .b(b_r),
    .done(mdone), .r(mres)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r <= IDX_W'(1024);
    end else if (cfg_wr_en) begin
      alen_r <= cfg_wr_data;
    end
  end

  // Top of stack, decoded for the query walk.
  logic [AW-1:0] t_n;
  logic [PW-1:0] t_lo, t_hi, t_mid;
  logic          t_cover;
  logic [$clog2(SP+1)-1:0] sp_top;
  assign sp_top  = sp_r - 1'b1;
  assign t_n     = stk_n_r[sp_top[$clog2(SP)-1:0]];
  assign t_lo    = stk_lo_r[sp_top[$clog2(SP)-1:0]];
  assign t_hi    = stk_hi_r[sp_top[$clog2(SP)-1:0]];
  assign t_mid   = PW'((32'(t_lo) + 32'(t_hi)) >> 1);
  assign t_cover = ({1'b0, qa_r} <= (IDX_W+1)'(t_lo)) && ((IDX_W+1)'(t_hi) <= {1'b0, qb_r});

  // Main sequencer.
  always_comb begin
    state_nxt = state_r;
    node_nxt  = node_r;
    ph_nxt    = ph_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    acc_v_nxt = acc_v_r;
    sum_nxt   = sum_r;
    st_nxt    = st_r;
    qa_nxt    = qa_r;
    qb_nxt    = qb_r;
    sp_nxt    = sp_r;
    push_a = 1'b0; push_b = 1'b0;
    pa_n = '0; pa_lo = '0; pa_hi = '0;
    pb_n = '0; pb_lo = '0; pb_hi = '0;
    we = 1'b0; waddr = node_r; wdata = mres;
    raddr = node_r;
    mstart = 1'b0;
    unique case (state_r)
      // Clearing pass: leaves get the zero matrix, then inner nodes bottom up.
      S_CLR: begin
        we = 1'b1; wdata = leaf_mat('0);
        if (node_r == AW'(NODES - 1)) begin
          node_nxt = AW'(LEAF_BASE - 1'b1);
          ph_nxt = 2'd0;
          state_nxt = S_CRD;
        end else begin
          node_nxt = node_r + 1'b1;
        end
      end
      S_CRD: begin
        raddr = {node_r[AW-2:0], ~ph_r[0]};
        state_nxt = S_CWT;
      end
      S_CWT: begin
        if (ph_r == 2'd0) begin
          a_nxt = rdata; ph_nxt = 2'd1; state_nxt = S_CRD;
        end else begin
          b_nxt = rdata; mstart = 1'b1; state_nxt = S_CMUL;
        end
      end
      S_CMUL: begin
        if (mdone) begin
          we = 1'b1;
          ph_nxt = 2'd0;
          if (node_r == AW'(1)) state_nxt = S_IDLE;
          else begin
            node_nxt = node_r - 1'b1;
            state_nxt = S_CRD;
          end
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (!i_mode) begin
            if (i_first != '0 && {1'b0, i_first} <= limit) begin
              we = 1'b1;
              waddr = AW'(LEAF_BASE) + AW'(i_first - 1'b1);
              wdata = leaf_mat(i_val);
              node_nxt = waddr >> 1;
              ph_nxt = 2'd0;
              state_nxt = (LVL == 0) ? S_IDLE : S_URD;
            end
          end else if (i_first == '0 || {1'b0, i_last} > limit || i_first > i_last) begin
            sum_nxt = '0; st_nxt = 1'b1; state_nxt = S_OUT;
          end else begin
            qa_nxt = i_first; qb_nxt = i_last;
            st_nxt = 1'b0; acc_v_nxt = 1'b0;
            sp_nxt = ($clog2(SP+1))'(1);
            push_b = 1'b1; pb_n = AW'(1); pb_lo = PW'(1); pb_hi = LEAF_BASE;
            state_nxt = S_QPOP;
          end
        end
      end
      // Update: recombine ancestors, left child as b, right child as a.
      S_URD: begin
        raddr = {node_r[AW-2:0], ~ph_r[0]};
        state_nxt = S_UWT;
      end
      S_UWT: begin
        if (ph_r == 2'd0) begin
          a_nxt = rdata; ph_nxt = 2'd1; state_nxt = S_URD;
        end else begin
          b_nxt = rdata; mstart = 1'b1; state_nxt = S_UMUL;
        end
      end
      S_UMUL: begin
        if (mdone) begin
          we = 1'b1;
          ph_nxt = 2'd0;
          if (node_r == AW'(1)) state_nxt = S_IDLE;
          else begin
            node_nxt = node_r >> 1;
            state_nxt = S_URD;
          end
        end
      end
      // Query: depth-first, leftmost covering node first; acc = node * acc.
      S_QPOP: begin
        if (sp_r == '0) begin
          sum_nxt = (acc_r[3] > acc_r[5]) ? acc_r[3] : acc_r[5];
          state_nxt = S_OUT;
        end else if (t_cover) begin
          node_nxt = t_n;
          sp_nxt = sp_r - 1'b1;
          state_nxt = S_QRD;
        end else begin
          // One child replaces the top; a split leaves the left child on top.
          if ({1'b0, qb_r} <= (IDX_W+1)'(t_mid)) begin
            push_a = 1'b1; pa_n = {t_n[AW-2:0], 1'b0}; pa_lo = t_lo; pa_hi = t_mid;
          end else if ({1'b0, qa_r} > (IDX_W+1)'(t_mid)) begin
            push_a = 1'b1; pa_n = {t_n[AW-2:0], 1'b1};
            pa_lo = t_mid + 1'b1; pa_hi = t_hi;
          end else begin
            push_a = 1'b1; pa_n = {t_n[AW-2:0], 1'b1};
            pa_lo = t_mid + 1'b1; pa_hi = t_hi;
            push_b = 1'b1; pb_n = {t_n[AW-2:0], 1'b0}; pb_lo = t_lo; pb_hi = t_mid;
            sp_nxt = sp_r + 1'b1;
          end
        end
      end
      S_QRD: begin
        state_nxt = S_QWT;
      end
      S_QWT: begin
        if (!acc_v_r) begin
          acc_nxt = rdata; acc_v_nxt = 1'b1; state_nxt = S_QPOP;
        end else begin
          a_nxt = rdata; b_nxt = acc_r; mstart = 1'b1; state_nxt = S_QMUL;
        end
      end
      S_QMUL: begin
        if (mdone) begin
          acc_nxt = mres; state_nxt = S_QPOP;
        end
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Stack writes: slot a at the current top, slot b above it.
  always_ff @(posedge clk) begin
    if (push_a) begin
      stk_n_r[sp_top[$clog2(SP)-1:0]]  <= pa_n;
      stk_lo_r[sp_top[$clog2(SP)-1:0]] <= pa_lo;
      stk_hi_r[sp_top[$clog2(SP)-1:0]] <= pa_hi;
    end
    if (push_b) begin
      stk_n_r[sp_r[$clog2(SP)-1:0]]  <= pb_n;
      stk_lo_r[sp_r[$clog2(SP)-1:0]] <= pb_lo;
      stk_hi_r[sp_r[$clog2(SP)-1:0]] <= pb_hi;
    end
  end

  // The first push in IDLE goes to slot zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      node_r  <= AW'(LEAF_BASE);
      ph_r    <= '0;
      sp_r    <= '0;
      acc_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      node_r  <= node_nxt;
      ph_r    <= ph_nxt;
      sp_r    <= sp_nxt;
      acc_v_r <= acc_v_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    sum_r <= sum_nxt;
    st_r  <= st_nxt;
    qa_r  <= qa_nxt;
    qb_r  <= qb_nxt;
  end

  `RMSS_ASSERT_IMP(a_out_idle, out_tvalid, !in_tready, "result shown while accepting")
  `RMSS_ASSERT_NEXT(a_bad_status, in_fire && i_mode && i_first == '0, out_tvalid && st_r,
    "bad query without error status")
  `RMSS_ASSERT_IMP(a_stack_bound, 1'b1, sp_r <= ($clog2(SP+1))'(SP), "query stack overflow")

endmodule

// ===== dv/range_sum_checker.sv =====
// Watches both channels of the block, keeps its own segment tree of max-plus
// matrices and compares every answer with the one the tree predicts.
module range_sum_checker
  import rmss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  output int          fail_count,
  output int          pending_answers,
  output int          query_count,
  output int          bad_query_count,
  output int          update_count
);

  localparam int NUM_LEAVES = 1024;
  localparam int TREE_NODES = 4 * NUM_LEAVES;
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    logic signed [31:0] best_sum;
    logic               status;
  } answer_t;

  typedef logic signed [31:0] cell3_t [9];

  cell3_t    tree_nodes [TREE_NODES];
  logic [10:0] length_reg;
  answer_t   answer_queue [$];

  function automatic cell3_t leaf_cells(input logic signed [15:0] v);
    cell3_t m;
    logic signed [31:0] e;
    e = 32'(v);
    m[0] = e;       m[1] = NEG_INF; m[2] = e;
    m[3] = e;       m[4] = 0;       m[5] = e;
    m[6] = NEG_INF; m[7] = NEG_INF; m[8] = 0;
    return m;
  endfunction

  // Max-plus product, each entry floored at minus infinity.
  function automatic cell3_t maxplus(input cell3_t a, input cell3_t b);
    cell3_t r;
    longint acc, s;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = longint'(NEG_INF);
        for (int k = 0; k < 3; k++) begin
          s = longint'(a[i*3+k]) + longint'(b[k*3+j]);
          if (s > acc) acc = s;
        end
        r[i*3+j] = acc[31:0];
      end
    end
    return r;
  endfunction

  function automatic void build_zero(input int node, input int lo, input int hi);
    int mid;
    if (lo == hi) begin
      tree_nodes[node] = leaf_cells(16'sd0);
      return;
    end
    mid = (lo + hi) >> 1;
    build_zero(2 * node, lo, mid);
    build_zero(2 * node + 1, mid + 1, hi);
    tree_nodes[node] = maxplus(tree_nodes[2*node+1], tree_nodes[2*node]);
  endfunction

  function automatic void write_leaf(input int node, input int lo, input int hi,
                                     input int pos, input logic signed [15:0] v);
    int mid;
    if (lo == hi) begin
      tree_nodes[node] = leaf_cells(v);
      return;
    end
    mid = (lo + hi) >> 1;
    if (pos <= mid) write_leaf(2 * node, lo, mid, pos, v);
    else write_leaf(2 * node + 1, mid + 1, hi, pos, v);
    tree_nodes[node] = maxplus(tree_nodes[2*node+1], tree_nodes[2*node]);
  endfunction

  function automatic cell3_t span_cells(input int node, input int lo, input int hi,
                                        input int a, input int b);
    int mid;
    if (a <= lo && hi <= b) return tree_nodes[node];
    mid = (lo + hi) >> 1;
    if (b <= mid) return span_cells(2 * node, lo, mid, a, b);
    if (a > mid) return span_cells(2 * node + 1, mid + 1, hi, a, b);
    return maxplus(span_cells(2 * node + 1, mid + 1, hi, a, b),
                   span_cells(2 * node, lo, mid, a, b));
  endfunction

  // Applies one accepted item to the predicted tree and queues any answer.
  function automatic void apply_item(input logic [39:0] d);
    logic mode;
    int first, last, limit;
    logic signed [15:0] v;
    cell3_t m;
    answer_t ans;
    mode  = d[0];
    first = d[11:1];
    last  = d[22:12];
    v     = d[38:23];
    limit = (length_reg < NUM_LEAVES) ? length_reg : NUM_LEAVES;
    if (mode == MODE_UPDATE) begin
      update_count++;
      if (first >= 1 && first <= limit) write_leaf(1, 1, NUM_LEAVES, first, v);
      return;
    end
    query_count++;
    if (first < 1 || last > limit || first > last) begin
      bad_query_count++;
      ans.best_sum = 0;
      ans.status   = STATUS_BAD;
    end else begin
      m = span_cells(1, 1, NUM_LEAVES, first, last);
      ans.best_sum = (m[3] > m[5]) ? m[3] : m[5];
      ans.status   = STATUS_OK;
    end
    answer_queue.push_back(ans);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    query_count = 0;
    bad_query_count = 0;
    update_count = 0;
    length_reg = 11'd1024;
    build_zero(1, 1, NUM_LEAVES);
  end

  assign pending_answers = answer_queue.size();

  // Sample both channels and the register port at each rising edge outside reset.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (cfg_wr_en) length_reg <= cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (answer_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected answer %h", out_tdata));
        end else begin
          want = answer_queue.pop_front();
          if (out_tdata[31:0] !== want.best_sum)
            report_mismatch($sformatf("best_sum %0d, predicted %0d",
                                      $signed(out_tdata[31:0]), want.best_sum));
          if (out_tdata[32] !== want.status)
            report_mismatch($sformatf("status %b, predicted %b",
                                      out_tdata[32], want.status));
          if (out_tdata[39:33] !== 7'd0)
            report_mismatch("fill bits of the answer not zero");
        end
      end
      if (in_tvalid && in_tready) apply_item(in_tdata);
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import rmss_pkg::*;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;
  localparam int   RANDOM_ITEMS = 1700;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  int          fail_count;
  int          pending_answers;
  int          query_count;
  int          bad_query_count;
  int          update_count;
  bit          quiet_phase;
  bit          hold_off;
  int          length_now;

  range_max_subarray_sum_tree dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  range_sum_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending_answers(pending_answers),
    .query_count(query_count), .bad_query_count(bad_query_count),
    .update_count(update_count)
  );

  // Clock with a period of 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offers one item and waits for it to be taken, with random gaps before.
  // The valid stays high after acceptance so that items can follow back to back.
  task automatic send_item(input logic mode, input logic [10:0] first,
                           input logic [10:0] last, input logic [15:0] v);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, v, last, first, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Register write once every answer is back and the block has gone quiet.
  task automatic write_length(input logic [10:0] len);
    in_tvalid <= 1'b0;
    while (pending_answers != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    length_now = len;
  endtask

  // Index within the active range most of the time; otherwise anywhere, just past the active edge, or zero.
  function automatic logic [10:0] pick_index();
    int lim;
    lim = (length_now < 1) ? 1 : length_now;
    case ($urandom_range(0, 9))
      0: return 11'($urandom_range(0, 2047));
      1: return 11'(lim + $urandom_range(0, 2));
      2: return 11'd0;
      default: return 11'($urandom_range(1, lim));
    endcase
  endfunction

  task automatic random_item();
    logic [10:0] a, b, t;
    logic [15:0] v;
    a = pick_index();
    b = pick_index();
    if ($urandom_range(0, 7) != 0 && a > b) begin
      t = a; a = b; b = t;
    end
    if ($urandom_range(0, 3) == 0) b = a + 11'($urandom_range(0, 8));
    case ($urandom_range(0, 3))
      0: v = 16'($urandom_range(0, 65535));
      1: v = 16'($urandom_range(0, 40)) - 16'd20;
      2: v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: v = 16'($urandom_range(0, 2000)) - 16'd1000;
    endcase
    send_item($urandom_range(0, 1) ? MODE_QUERY : MODE_UPDATE, a, b, v);
  endtask

  // Receiver readiness: random stall bursts, one long hold-off when asked.
  initial begin
    int burst;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 11);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Long receiver hold-off counted in its own process, once the tree is cleared.
  initial begin
    @(posedge rst_n);
    @(posedge clk iff in_tready);
    repeat (4000) @(posedge clk);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    quiet_phase = 1'b0;
    hold_off    = 1'b0;
    length_now  = 1024;
    rst_n       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and every bad-range case.
    send_item(MODE_QUERY, 11'd1, 11'd1024, 16'h0000);
    send_item(MODE_UPDATE, 11'd1, 11'd0, 16'h7fff);
    send_item(MODE_UPDATE, 11'd1024, 11'h7ff, 16'h8000);
    send_item(MODE_UPDATE, 11'd2, 11'd0, 16'hffff);
    send_item(MODE_UPDATE, 11'd0, 11'd5, 16'h1234);
    send_item(MODE_UPDATE, 11'h7ff, 11'd5, 16'h5555);
    send_item(MODE_QUERY, 11'd1, 11'd1, 16'hffff);
    send_item(MODE_QUERY, 11'd1, 11'd2, 16'h0000);
    send_item(MODE_QUERY, 11'd1024, 11'd1024, 16'h0000);
    send_item(MODE_QUERY, 11'd1, 11'd1024, 16'h0000);
    send_item(MODE_QUERY, 11'd2, 11'd2, 16'h0000);
    send_item(MODE_QUERY, 11'd0, 11'd5, 16'h0000);
    send_item(MODE_QUERY, 11'd5, 11'd1025, 16'h0000);
    send_item(MODE_QUERY, 11'd9, 11'd3, 16'h0000);
    send_item(MODE_QUERY, 11'h7ff, 11'h7ff, 16'hffff);
    send_item(MODE_QUERY, 11'd512, 11'd513, 16'h0000);

    // Small active length, zero, one, and back to full and beyond.
    write_length(11'd1);
    send_item(MODE_UPDATE, 11'd1, 11'd0, 16'd77);
    send_item(MODE_UPDATE, 11'd2, 11'd0, 16'd88);
    send_item(MODE_QUERY, 11'd1, 11'd1, 16'h0000);
    send_item(MODE_QUERY, 11'd1, 11'd2, 16'h0000);
    write_length(11'd0);
    send_item(MODE_UPDATE, 11'd1, 11'd0, 16'd5);
    send_item(MODE_QUERY, 11'd1, 11'd1, 16'h0000);
    write_length(11'h7ff);
    send_item(MODE_QUERY, 11'd1, 11'd1024, 16'h0000);

    // Random phases under several lengths.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_length(11'd1024);
        1: write_length(11'd16);
        2: write_length(11'($urandom_range(2, 1023)));
        3: write_length(11'd1024);
        default: write_length(11'd40);
      endcase
      if (phase == 4) quiet_phase = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) random_item();
    end

    in_tvalid <= 1'b0;
    while (pending_answers != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Covered %0d updates and %0d queries (%0d with a bad range)",
             update_count, query_count, bad_query_count);
    $display("across active lengths from zero to the full tree, with stalls.");
    if (fail_count == 0) begin
      $display("range_max_subarray_sum_tree test passed");
    end else begin
      $display("range_max_subarray_sum_tree test failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #100000000;
    $display("range_max_subarray_sum_tree test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rmss_pkg.sv
sv/rmss_ram.sv
sv/rmss_mul.sv
sv/range_max_subarray_sum_tree.sv
dv/range_sum_checker.sv
dv/tb_top.sv
